[rtl/midi_triggered_sample_player_macros.svh]
// Assertion macros used by the sample player checker.
// Uses the checker's clock and reset port names.
`ifndef MIDI_TRIGGERED_SAMPLE_PLAYER_MACROS_SVH
`define MIDI_TRIGGERED_SAMPLE_PLAYER_MACROS_SVH

// Checked outside reset.
`define MTSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MTSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/mtsp_pkg.sv]
// Shared constants, types and the gain lookup for the sample player.
// No dependencies; imported by every module of the block.
package mtsp_pkg;

   localparam int VOICES      = 3;
   localparam int MEM_WORDS   = 65536;
   localparam int SAMPLE_BITS = 16;

   localparam int NUM_REG_VOICES = 3;
   localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int MEM_AW  = $clog2(VOICES * MEM_WORDS);
   localparam int MEM_DW  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int CHAN_W  = 2;
   localparam int LEN_W   = 17;
   localparam int GAIN_W  = 17;
   localparam int GAIN_FRAC = 16;
   localparam int OUT_W   = 18;
   localparam int ACC_W   = OUT_W + VIDX_W;
   localparam int PROD_W  = MEM_DW + GAIN_W + 1;

   // Stream packing
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int ST_LSB   = 0;
   localparam int NOTE_LSB = 8;
   localparam int VEL_LSB  = 15;
   localparam int SEL_LSB  = 22;
   localparam int ADDR_LSB = 24;
   localparam int VAL_LSB  = 40;

   // CSR port
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NOTE_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_BASE = 3'd3;

   // Commands carried in req_tuser
   localparam logic [1:0] CMD_EVENT = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;

   localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
   localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

   localparam logic [NOTE_W-1:0] NOTE_RESET = 7'd40;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;
   localparam int CLAMP_MAX = 32767;

   // gain = round(vel * 65536 / 127) = 516*vel + floor((4*vel + 63) / 127)
   localparam int VEL_FULL   = 127;
   localparam int GAIN_STEP  = 65536 / VEL_FULL;
   localparam int GAIN_REM   = 65536 - GAIN_STEP * VEL_FULL;
   localparam int ROUND_BIAS = VEL_FULL / 2;

   typedef struct packed {
      logic [VOICES-1:0][NOTE_W-1:0] note;
      logic [VOICES-1:0][CHAN_W-1:0] chan;
   } cfg_type;

   function automatic logic [GAIN_W-1:0] gain_of(input logic [VEL_W-1:0] vel);
      logic [GAIN_W-1:0] base;
      logic [9:0]        rem;
      logic [2:0]        q;
      base = GAIN_W'(vel) * GAIN_W'(GAIN_STEP);
      rem  = 10'(vel) * 10'(GAIN_REM) + 10'(ROUND_BIAS);
      q    = '0;
      for (int k = 1; k <= GAIN_REM; k++) begin
         if (rem >= 10'(k * VEL_FULL)) begin
            q = q + 3'd1;
         end
      end
      return base + GAIN_W'(q);
   endfunction

endpackage

[rtl/mtsp_csr.sv]
// APB-style register file: trigger note and channel count per voice.
// Depends on mtsp_pkg.
module mtsp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mtsp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [mtsp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [mtsp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output mtsp_pkg::cfg_type             cfg
);
   import mtsp_pkg::*;

   logic [NOTE_W-1:0] note_ff [VOICES];
   logic [NOTE_W-1:0] note_in [VOICES];
   logic [CHAN_W-1:0] chan_ff [VOICES];
   logic [CHAN_W-1:0] chan_in [VOICES];
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_beat;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      for (int v = 0; v < VOICES; v++) begin
         note_in[v] = note_ff[v];
         chan_in[v] = chan_ff[v];
         if (v < NUM_REG_VOICES) begin
            if (reg_idx == REG_NOTE_BASE + CSR_IDX_W'(v)) begin
               csr_prdata = CSR_DW'(note_ff[v]);
               if (wr_beat) begin
                  note_in[v] = csr_pwdata[NOTE_W-1:0];
               end
            end
            if (reg_idx == REG_CHAN_BASE + CSR_IDX_W'(v)) begin
               csr_prdata = CSR_DW'(chan_ff[v]);
               if (wr_beat) begin
                  chan_in[v] = csr_pwdata[CHAN_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            note_ff[v] <= NOTE_RESET;
            chan_ff[v] <= CHAN_RESET;
         end
      end else begin
         note_ff <= note_in;
         chan_ff <= chan_in;
      end
   end

   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         cfg.note[v] = note_ff[v];
         cfg.chan[v] = chan_ff[v];
      end
   end

endmodule

[rtl/midi_triggered_sample_player.sv]
// One-shot drum sampler: per-voice sample memory, note triggers and stereo mix.
// Depends on mtsp_pkg and mtsp_csr.
//
// Usage:
//   req channel takes one item per beat; req_tuser is the command (MIDI event,
//   frame tick, sample load). Events and loads are absorbed in the beat that
//   carries them, so they stream at one per cycle while no tick is being mixed.
//   A frame tick walks the voices one after another through the single read
//   port of the sample RAM: a playing voice passes read (S_VOICE), multiply
//   and second read for stereo (S_MUL_A), accumulate (S_ACC_A, plus S_ACC_B
//   for stereo) and advance (S_ADV); a skipped or silent voice only S_VOICE.
//   The sum is then registered in S_DONE; req is held off during that walk.
//   rsp channel carries one left/right pair per tick from an output register;
//   loads and events keep flowing while a result waits. A tick that finishes
//   while the previous result is still unread holds until rsp_tready.
//   Reset clears voice lengths, positions, latches and gains (unity); the
//   sample RAM is not cleared and a word reads valid once loaded.
//   csr port: notes at 0x00..0x08, channel counts at 0x0C..0x14; write when idle.
module midi_triggered_sample_player (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: status_byte, note, velocity, voice_select, load_address, load_value
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mtsp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: cmd
   input  logic [mtsp_pkg::REQ_USER_W-1:0]   req_tuser,
   // rsp_tdata: out_left, out_right, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mtsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mtsp_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [mtsp_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [mtsp_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import mtsp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_VOICE = 7'b0000010,
      S_MUL_A = 7'b0000100,
      S_ACC_A = 7'b0001000,
      S_ACC_B = 7'b0010000,
      S_ADV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(CLAMP_MAX);

   cfg_type cfg;

   mtsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input fields
   logic [1:0]        in_cmd;
   logic [7:0]        in_status;
   logic [NOTE_W-1:0] in_note;
   logic [VEL_W-1:0]  in_vel;
   logic [1:0]        in_sel;
   logic [15:0]       in_addr;
   logic [15:0]       in_val;
   logic              accept;

   assign in_cmd    = req_tuser[1:0];
   assign in_status = req_tdata[ST_LSB +: 8];
   assign in_note   = req_tdata[NOTE_LSB +: NOTE_W];
   assign in_vel    = req_tdata[VEL_LSB +: VEL_W];
   assign in_sel    = req_tdata[SEL_LSB +: 2];
   assign in_addr   = req_tdata[ADDR_LSB +: 16];
   assign in_val    = req_tdata[VAL_LSB +: 16];

   // Control and voice state
   state_type state_ff, state_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;

   logic [LEN_W-1:0]  len_ff     [VOICES];
   logic [LEN_W-1:0]  len_in     [VOICES];
   logic [LEN_W-1:0]  pos_ff     [VOICES];
   logic [LEN_W-1:0]  pos_in     [VOICES];
   logic              playing_ff [VOICES];
   logic              playing_in [VOICES];
   logic [GAIN_W-1:0] gain_ff    [VOICES];
   logic [GAIN_W-1:0] gain_in    [VOICES];
   logic [VEL_W-1:0]  pvel_ff    [VOICES];
   logic [VEL_W-1:0]  pvel_in    [VOICES];
   logic              match_ff   [VOICES];
   logic              match_in   [VOICES];

   // Working registers for the voice being mixed
   logic [GAIN_W-1:0] cur_gain_ff, cur_gain_in;
   logic [LEN_W-1:0]  cur_pos_ff, cur_pos_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [CHAN_W-1:0] cur_ch_ff, cur_ch_in;
   logic              rd_zero_ff, rd_zero_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  left_ff, left_in;
   logic signed [ACC_W-1:0]  right_ff, right_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_left_ff, rsp_left_in;
   logic [OUT_W-1:0]  rsp_right_ff, rsp_right_in;

   // Sample RAM ports
   logic [MEM_DW-1:0] sample_mem [VOICES * MEM_WORDS];
   logic [MEM_DW-1:0] rd_word_ff;
   logic              rd_en, wr_en;
   logic [MEM_AW-1:0] rd_addr, wr_addr, vbase;
   logic [MEM_DW-1:0] wr_data;

   // Per-voice decode
   logic              v_trig, v_skip, last_voice;
   logic [GAIN_W-1:0] v_gain;
   logic [LEN_W-1:0]  v_pos, next_pos;
   logic signed [MEM_DW-1:0] mul_a;
   logic signed [PROD_W-1:0] prod_mul;
   logic signed [ACC_W-1:0]  contrib;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign v_trig     = match_ff[vidx_ff] && (pvel_ff[vidx_ff] != '0);
   assign v_skip     = (len_ff[vidx_ff] == '0) || (cfg.chan[vidx_ff] == '0);
   assign v_gain     = gain_of(pvel_ff[vidx_ff]);
   assign v_pos      = v_trig ? '0 : pos_ff[vidx_ff];
   assign last_voice = (vidx_ff == VIDX_W'(VOICES - 1));
   assign vbase      = MEM_AW'(vidx_ff) * MEM_AW'(MEM_WORDS);
   assign next_pos   = cur_pos_ff + LEN_W'(cur_ch_ff);

   assign mul_a    = rd_zero_ff ? '0 : $signed(rd_word_ff);
   assign prod_mul = PROD_W'(mul_a) * PROD_W'($signed({1'b0, cur_gain_ff}));
   assign contrib  = ACC_W'($signed(prod_ff[GAIN_FRAC +: MEM_DW]));

   always_comb begin
      state_in     = state_ff;
      vidx_in      = vidx_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      playing_in   = playing_ff;
      gain_in      = gain_ff;
      pvel_in      = pvel_ff;
      match_in     = match_ff;
      cur_gain_in  = cur_gain_ff;
      cur_pos_in   = cur_pos_ff;
      cur_len_in   = cur_len_ff;
      cur_ch_in    = cur_ch_ff;
      rd_zero_in   = rd_zero_ff;
      prod_in      = prod_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = in_val[MEM_DW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (in_cmd)
                  CMD_EVENT: begin
                     if (in_status[7:4] == STATUS_NOTE_ON) begin
                        // first matching note-on since the last tick wins
                        for (int v = 0; v < VOICES; v++) begin
                           if (!match_ff[v] && in_note == cfg.note[v]) begin
                              match_in[v] = 1'b1;
                              pvel_in[v]  = in_vel;
                           end
                        end
                     end
                  end
                  CMD_LOAD: begin
                     if (32'(in_sel) < VOICES && 32'(in_addr) < MEM_WORDS) begin
                        wr_en   = 1'b1;
                        wr_addr = MEM_AW'(in_sel) * MEM_AW'(MEM_WORDS) + MEM_AW'(in_addr);
                        for (int v = 0; v < VOICES; v++) begin
                           if (32'(in_sel) == v &&
                               (LEN_W'(in_addr) + LEN_W'(1)) > len_ff[v]) begin
                              len_in[v] = LEN_W'(in_addr) + LEN_W'(1);
                           end
                        end
                     end
                  end
                  CMD_TICK: begin
                     left_in  = '0;
                     right_in = '0;
                     vidx_in  = '0;
                     state_in = S_VOICE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_VOICE: begin
            // drop the latch whether or not the voice plays
            match_in[vidx_ff] = 1'b0;
            pvel_in[vidx_ff]  = '0;
            cur_gain_in = v_trig ? v_gain : gain_ff[vidx_ff];
            cur_pos_in  = v_pos;
            cur_len_in  = len_ff[vidx_ff];
            cur_ch_in   = cfg.chan[vidx_ff];
            rd_zero_in  = 1'b0;
            if (!v_skip && v_trig) begin
               playing_in[vidx_ff] = 1'b1;
               gain_in[vidx_ff]    = v_gain;
               pos_in[vidx_ff]     = '0;
            end
            if (!v_skip && (v_trig || playing_ff[vidx_ff])) begin
               rd_en    = 1'b1;
               rd_addr  = vbase + MEM_AW'(v_pos);
               state_in = S_MUL_A;
            end else if (last_voice) begin
               state_in = S_DONE;
            end else begin
               vidx_in = vidx_ff + VIDX_W'(1);
            end
         end
         S_MUL_A: begin
            prod_in  = prod_mul;
            state_in = S_ACC_A;
            if (cur_ch_ff == CHAN_STEREO) begin
               // right word past the end of the voice reads as zero
               rd_zero_in = ({1'b0, cur_pos_ff} + (LEN_W + 1)'(1)) >= {1'b0, cur_len_ff};
               if (!rd_zero_in) begin
                  rd_en   = 1'b1;
                  rd_addr = vbase + MEM_AW'(cur_pos_ff) + MEM_AW'(1);
               end
            end
         end
         S_ACC_A: begin
            state_in = S_ADV;
            if (cur_ch_ff == CHAN_MONO) begin
               left_in  = left_ff + contrib;
               right_in = right_ff + contrib;
            end else if (cur_ch_ff == CHAN_STEREO) begin
               left_in  = left_ff + contrib;
               prod_in  = prod_mul;
               state_in = S_ACC_B;
            end
         end
         S_ACC_B: begin
            right_in = right_ff + contrib;
            state_in = S_ADV;
         end
         S_ADV: begin
            left_in  = (left_ff > SUM_MAX) ? SUM_MAX : left_ff;
            right_in = (right_ff > SUM_MAX) ? SUM_MAX : right_ff;
            if (next_pos >= cur_len_ff) begin
               pos_in[vidx_ff]     = '0;
               playing_in[vidx_ff] = 1'b0;
            end else begin
               pos_in[vidx_ff] = next_pos;
            end
            if (last_voice) begin
               state_in = S_DONE;
            end else begin
               vidx_in  = vidx_ff + VIDX_W'(1);
               state_in = S_VOICE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_ff[OUT_W-1:0];
               rsp_right_in = right_ff[OUT_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            len_ff[v]     <= '0;
            pos_ff[v]     <= '0;
            playing_ff[v] <= 1'b0;
            gain_ff[v]    <= GAIN_UNITY;
            pvel_ff[v]    <= '0;
            match_ff[v]   <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         vidx_ff      <= vidx_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         gain_ff      <= gain_in;
         pvel_ff      <= pvel_in;
         match_ff     <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_gain_ff  <= cur_gain_in;
      cur_pos_ff   <= cur_pos_in;
      cur_len_ff   <= cur_len_in;
      cur_ch_ff    <= cur_ch_in;
      rd_zero_ff   <= rd_zero_in;
      prod_ff      <= prod_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // Sample RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= sample_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2 * OUT_W)'(0), rsp_right_ff, rsp_left_ff};

endmodule

[rtl/mtsp_checker.sv]
// Port-level checks for the sample player, bound to the top level.
// Depends on mtsp_pkg and the shared assertion macros.
`include "midi_triggered_sample_player_macros.svh"

module mtsp_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [mtsp_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mtsp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import mtsp_pkg::*;

   `MTSP_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "result beat valid after reset")

   `MTSP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")

   `MTSP_ASSERT(a_tick_blocks, req_tvalid && req_tready && req_tuser == CMD_TICK |=> !req_tready, "input open during mix")

   `MTSP_ASSERT(a_other_flows, req_tvalid && req_tready && req_tuser != CMD_TICK |=> req_tready, "event or load stalled input")

endmodule

bind midi_triggered_sample_player mtsp_checker u_mtsp_checker (.*);
